// ----- rtl/nsp_pkg.sv -----
package nsp_pkg;

  localparam int unsigned LEN_CAP          = 200000000;
  localparam int unsigned PREFIX_BUDGET_RST = 100;
  localparam int unsigned ADDR_LIMIT_RST    = 1000;

  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned BUDGET_W   = 10;
  localparam int unsigned LIMIT_W    = 16;

  localparam logic REG_PREFIX_BUDGET = 1'b0;
  localparam logic REG_ADDR_LIMIT    = 1'b1;

  typedef enum logic [1:0] {
    KIND_FRAME  = 2'd0,
    KIND_BODY   = 2'd1,
    KIND_SENDER = 2'd2,
    KIND_RECIP  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_PROTO = 2'd1,
    ERR_LEN   = 2'd2
  } err_e;

  typedef enum logic [11:0] {
    PH_OUTER_LEN = 12'b0000_0000_0001,
    PH_MSG_LEN   = 12'b0000_0000_0010,
    PH_MSG_BODY  = 12'b0000_0000_0100,
    PH_MSG_COMMA = 12'b0000_0000_1000,
    PH_S_LEN     = 12'b0000_0001_0000,
    PH_S_DATA    = 12'b0000_0010_0000,
    PH_S_COMMA   = 12'b0000_0100_0000,
    PH_R_LEN     = 12'b0000_1000_0000,
    PH_R_DATA    = 12'b0001_0000_0000,
    PH_R_COMMA   = 12'b0010_0000_0000,
    PH_FINAL     = 12'b0100_0000_0000,
    PH_DONE      = 12'b1000_0000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       is_digit;
    logic       is_colon;
    logic       is_comma;
    logic       is_nul;
    logic [3:0] digit;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
    logic       addr_ok;
    logic       fin;
    logic       acc;
    err_e       err;
  } res_t;

  typedef struct packed {
    logic empty;
    logic pop;
  } qctl_t;

endpackage

// ----- rtl/nsp_fifo.sv -----
module nsp_fifo #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o
);

  logic [DW-1:0] mem_q [2];
  logic          wr_ptr_q, wr_ptr_d;
  logic          rd_ptr_q, rd_ptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/nsp_front.sv -----
module nsp_front
  import nsp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_byte_i,
  output logic       full_o,
  input  logic       item_pop_i,
  output logic       item_empty_o,
  output item_t      item_o
);

  item_t                cls;
  logic [$bits(item_t)-1:0] item_raw;

  // byte classification ahead of the queue
  always_comb begin
    cls.data     = data_byte_i;
    cls.is_digit = (data_byte_i >= CH_ZERO) && (data_byte_i <= CH_NINE);
    cls.is_colon = (data_byte_i == CH_COLON);
    cls.is_comma = (data_byte_i == CH_COMMA);
    cls.is_nul   = (data_byte_i == CH_NUL);
    cls.digit    = data_byte_i[3:0];
  end

  nsp_fifo #(
    .DW($bits(item_t))
  ) u_item_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push_i),
    .data_i (cls),
    .full_o (full_o),
    .empty_o(item_empty_o),
    .pop_i  (item_pop_i),
    .data_o (item_raw)
  );

  assign item_o = item_t'(item_raw);

endmodule

// ----- rtl/nsp_back.sv -----
module nsp_back
  import nsp_pkg::*;
#(
  parameter int CW = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  item_t                 item_i,
  input  logic                  item_empty_i,
  output logic                  item_pop_o,
  output qctl_t                 res_ctl_o,
  input  logic                  res_pop_i,
  output res_t                  res_o
);

  localparam logic [CW-1:0] LenCap = CW'(LEN_CAP);

  phase_e            phase_q, phase_d;
  logic [CW-1:0]     outer_budget_q, outer_budget_d;
  logic [CW-1:0]     length_acc_q, length_acc_d;
  logic [CW-1:0]     field_left_q, field_left_d;
  logic              nul_seen_q, nul_seen_d;
  logic              all_ok_q, all_ok_d;
  logic              halted_q, halted_d;
  logic [LIMIT_W-1:0] addr_limit_q;
  logic [CW-1:0]     budget_dec;
  logic              res_full;
  logic              step;
  res_t              res;
  logic [$bits(res_t)-1:0] res_raw;

  assign step       = !item_empty_i && !res_full;
  assign item_pop_o = step;
  assign budget_dec = outer_budget_q - 1'b1;

  always_comb begin
    phase_d        = phase_q;
    outer_budget_d = outer_budget_q;
    length_acc_d   = length_acc_q;
    field_left_d   = field_left_q;
    nul_seen_d     = nul_seen_q;
    all_ok_d       = all_ok_q;
    halted_d       = halted_q;
    res.data       = item_i.data;
    res.kind       = KIND_FRAME;
    res.last       = 1'b0;
    res.addr_ok    = 1'b0;
    res.fin        = 1'b0;
    res.acc        = 1'b0;
    res.err        = ERR_NONE;
    if (step && !halted_q) begin
      if (outer_budget_q == '0) begin
        res.err = ERR_PROTO;
      end else begin
        outer_budget_d = budget_dec;
        unique case (phase_q)
          PH_OUTER_LEN, PH_MSG_LEN, PH_S_LEN, PH_R_LEN: begin
            if (length_acc_q > LenCap) begin
              res.err = ERR_LEN;
            end else if (item_i.is_colon) begin
              length_acc_d = '0;
              priority if (phase_q == PH_OUTER_LEN) begin
                outer_budget_d = length_acc_q;
                phase_d        = PH_MSG_LEN;
              end else if (phase_q == PH_MSG_LEN) begin
                field_left_d = length_acc_q;
                phase_d      = (length_acc_q != '0) ? PH_MSG_BODY : PH_MSG_COMMA;
              end else if (phase_q == PH_S_LEN) begin
                field_left_d = length_acc_q;
                nul_seen_d   = (length_acc_q >= CW'(addr_limit_q));
                phase_d      = (length_acc_q != '0) ? PH_S_DATA : PH_S_COMMA;
              end else begin
                field_left_d = length_acc_q;
                nul_seen_d   = (length_acc_q >= CW'(addr_limit_q));
                phase_d      = (length_acc_q != '0) ? PH_R_DATA : PH_R_COMMA;
              end
            end else if (!item_i.is_digit) begin
              res.err = ERR_PROTO;
            end else begin
              length_acc_d = (length_acc_q << 3) + (length_acc_q << 1) + CW'(item_i.digit);
            end
          end
          PH_MSG_BODY, PH_S_DATA, PH_R_DATA: begin
            field_left_d = field_left_q - 1'b1;
            priority if (phase_q == PH_MSG_BODY) begin
              res.kind = KIND_BODY;
              if (field_left_q == CW'(1)) begin
                phase_d = PH_MSG_COMMA;
              end
            end else if (phase_q == PH_S_DATA) begin
              res.kind = KIND_SENDER;
              if (item_i.is_nul) begin
                nul_seen_d = 1'b1;
              end
              if (field_left_q == CW'(1)) begin
                phase_d = PH_S_COMMA;
              end
            end else begin
              res.kind = KIND_RECIP;
              if (item_i.is_nul) begin
                nul_seen_d = 1'b1;
              end
              if (field_left_q == CW'(1)) begin
                phase_d = PH_R_COMMA;
              end
            end
          end
          PH_MSG_COMMA: begin
            if (!item_i.is_comma) begin
              res.err = ERR_PROTO;
            end else begin
              phase_d = PH_S_LEN;
            end
          end
          PH_S_COMMA, PH_R_COMMA: begin
            if (!item_i.is_comma) begin
              res.err = ERR_PROTO;
            end else begin
              res.kind    = (phase_q == PH_S_COMMA) ? KIND_SENDER : KIND_RECIP;
              res.last    = 1'b1;
              res.addr_ok = !nul_seen_q;
              if (nul_seen_q) begin
                all_ok_d = 1'b0;
              end
              nul_seen_d = 1'b0;
              if (budget_dec == '0) begin
                outer_budget_d = CW'(1);
                phase_d        = PH_FINAL;
              end else begin
                phase_d = PH_R_LEN;
              end
            end
          end
          PH_FINAL: begin
            if (!item_i.is_comma) begin
              res.err = ERR_PROTO;
            end else begin
              res.fin  = 1'b1;
              res.acc  = all_ok_q;
              phase_d  = PH_DONE;
              halted_d = 1'b1;
            end
          end
          default: begin
            halted_d = 1'b1;
          end
        endcase
      end
      if (res.err != ERR_NONE) begin
        halted_d = 1'b1;
      end
    end
    // budget register reloads the prefix budget while the outer length is open and the parser has not halted
    if (cfg_we_i && cfg_addr_i == REG_PREFIX_BUDGET && phase_q == PH_OUTER_LEN &&
        !halted_q) begin
      outer_budget_d = CW'(cfg_wdata_i[BUDGET_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_OUTER_LEN;
      outer_budget_q <= CW'(PREFIX_BUDGET_RST);
      length_acc_q   <= '0;
      field_left_q   <= '0;
      nul_seen_q     <= 1'b0;
      all_ok_q       <= 1'b1;
      halted_q       <= 1'b0;
      addr_limit_q   <= LIMIT_W'(ADDR_LIMIT_RST);
    end else begin
      phase_q        <= phase_d;
      outer_budget_q <= outer_budget_d;
      length_acc_q   <= length_acc_d;
      field_left_q   <= field_left_d;
      nul_seen_q     <= nul_seen_d;
      all_ok_q       <= all_ok_d;
      halted_q       <= halted_d;
      if (cfg_we_i && cfg_addr_i == REG_ADDR_LIMIT) begin
        addr_limit_q <= cfg_wdata_i[LIMIT_W-1:0];
      end
    end
  end

  nsp_fifo #(
    .DW($bits(res_t))
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step),
    .data_i (res),
    .full_o (res_full),
    .empty_o(res_ctl_o.empty),
    .pop_i  (res_pop_i),
    .data_o (res_raw)
  );

  assign res_ctl_o.pop = res_pop_i && !res_ctl_o.empty;
  assign res_o         = res_t'(res_raw);

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q && !cfg_we_i |=> halted_q)
    else $error("halt flag cleared");

  a_last_is_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.last |-> (res.kind == KIND_SENDER || res.kind == KIND_RECIP))
    else $error("field_last outside an address");

  a_empty_budget_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !halted_q && outer_budget_q == '0 |=> halted_q)
    else $error("exhausted budget did not halt");

  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && res.err != ERR_NONE |-> !res.last && !res.fin && res.kind == KIND_FRAME)
    else $error("error beat carries field flags");

endmodule

// ----- rtl/qmqp_netstring_parser_unit.sv -----
// path: a pushed byte is registered in the item queue, then in the result queue, before it is popped
// throughput: one beat per cycle in steady state while the result queue is not full,
// set by the length/budget update that the back end makes as it takes each beat
// a two-entry queue sits between front and back and another on the result side
// reset: asynchronous, active low; parser returns to the outer length prefix with
// budget 100, address limit 1000, and both queues empty
module qmqp_netstring_parser_unit
  import nsp_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            data_byte_i,
  output logic                  empty,
  input  logic                  pop,
  output logic [7:0]            out_byte_o,
  output logic [1:0]            field_kind_o,
  output logic                  field_last_o,
  output logic                  address_ok_o,
  output logic                  finished_o,
  output logic                  accepted_o,
  output logic [1:0]            error_code_o,
  input  logic                  cfg_we_i,
  input  logic                  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  item_t item;
  logic  item_empty;
  logic  item_pop;
  qctl_t res_ctl;
  res_t  res;

  nsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_byte_i (data_byte_i),
    .full_o      (full),
    .item_pop_i  (item_pop),
    .item_empty_o(item_empty),
    .item_o      (item)
  );

  nsp_back #(
    .CW(COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item),
    .item_empty_i(item_empty),
    .item_pop_o  (item_pop),
    .res_ctl_o   (res_ctl),
    .res_pop_i   (pop),
    .res_o       (res)
  );

  assign empty        = res_ctl.empty;
  assign out_byte_o   = res.data;
  assign field_kind_o = res.kind;
  assign field_last_o = res.last;
  assign address_ok_o = res.addr_ok;
  assign finished_o   = res.fin;
  assign accepted_o   = res.acc;
  assign error_code_o = res.err;

  a_pop_only_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_ctl.pop |-> !empty)
    else $error("result pop while empty");

  a_fin_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && finished_o |-> error_code_o == ERR_NONE && !field_last_o)
    else $error("finish beat carries error or field flag");

  a_ok_needs_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && address_ok_o |-> field_last_o)
    else $error("address verdict without field close");

endmodule
